// ===== design/amwm_pkg.sv =====
package amwm_pkg;

  // Fixed-point scale and limits.
  localparam int Q14_ONE = 16384;
  localparam logic [32:0] Q28_ONE = 33'd268435456;

  // CORDIC sine and cosine.
  localparam int CORDIC_STEPS = 14;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Stage counts: input capture, CORDIC, rotation, mixing, peak search.
  localparam int FRONT_STAGES = 22;

  // Normalizing divider geometry.
  localparam int QUO_W = 15;
  localparam int DEN_W = 33;
  localparam int NUM_W = 48;

  // Register indexes of the configuration port.
  localparam logic REG_DRIVE_MODE  = 1'b0;
  localparam logic REG_INVERT_MASK = 1'b1;

  // Drivetrain codes.
  localparam logic [1:0] MODE_TANK    = 2'd0;
  localparam logic [1:0] MODE_MECANUM = 2'd1;
  localparam logic [1:0] MODE_SWERVE  = 2'd2;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic signed [15:0] atan_bam(input logic [3:0] i);
    logic signed [15:0] r;
    case (i)
      4'd0:    r = 16'sd8192;
      4'd1:    r = 16'sd4836;
      4'd2:    r = 16'sd2555;
      4'd3:    r = 16'sd1297;
      4'd4:    r = 16'sd651;
      4'd5:    r = 16'sd326;
      4'd6:    r = 16'sd163;
      4'd7:    r = 16'sd81;
      4'd8:    r = 16'sd41;
      4'd9:    r = 16'sd20;
      4'd10:   r = 16'sd10;
      4'd11:   r = 16'sd5;
      4'd12:   r = 16'sd3;
      4'd13:   r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  // Divide by 2^14, rounding half away from zero.
  function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] mag;
    logic signed [47:0] q;
    mag = (v < 0) ? -v : v;
    q = (mag + 48'sd8192) >>> 14;
    return (v < 0) ? -q : q;
  endfunction

  // Saturate to plus or minus 1.0 in Q2.14.
  function automatic logic signed [15:0] sat14(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd16384) r = 16'sd16384;
    else if (v < -48'sd16384) r = -16'sd16384;
    else r = 16'(v);
    return r;
  endfunction

  // Q30 to Q14 with floor rounding of v + 2^15, then saturation.
  function automatic logic signed [15:0] q30_to_q14(input logic signed [31:0] v);
    logic signed [47:0] t;
    t = (48'(v) + 48'sd32768) >>> 16;
    return sat14(t);
  endfunction

  // Magnitude of a wheel product.
  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = (v < 0) ? -v : v;
    return 33'(a);
  endfunction

endpackage

// ===== design/amwm_div.sv =====
module amwm_div import amwm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [NUM_W-1:0] rem_nxt [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [DEN_W-1:0] den_nxt [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];

  // One restoring step per stage, most significant quotient bit first.
  always_comb begin
    logic [NUM_W-1:0] rin;
    logic [NUM_W-1:0] sh;
    logic [QUO_W-1:0] qin;
    for (int j = 0; j < QUO_W; j++) begin
      rin = (j == 0) ? num : rem_r[j-1];
      den_nxt[j] = (j == 0) ? den : den_r[j-1];
      qin = (j == 0) ? '0 : quo_r[j-1];
      sh = NUM_W'(den_nxt[j]) << (QUO_W - 1 - j);
      rem_nxt[j] = rin;
      quo_nxt[j] = qin;
      if (rin >= sh) begin
        rem_nxt[j] = rin - sh;
        quo_nxt[j][QUO_W-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== design/arcade_mecanum_wheel_mixer.sv =====
// Channel  Dir  Fields (lowest bit first)
// in_      in   tdata: stick_x, stick_y, stick_z, throttle, gyro_angle (16 bits each)
// out_     out  tdata: front_left, rear_left, front_right, rear_right; tuser: updated
// cfg_     in   cfg_idx 0 drive_mode, 1 invert_mask; cfg_wdata 4 bits
//
// One word is accepted every cycle while the output word is not held.
// The depth comes from the 14-stage CORDIC and the 15-stage normalizing divider.
// Reset (rst_n low, synchronous) empties the pipeline and clears both registers.
// When the output word is held, the whole pipeline stops and in_tready drops.
module arcade_mecanum_wheel_mixer import amwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // stick_x, stick_y, stick_z, throttle, gyro_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // front_left, rear_left, front_right, rear_right
  output logic [0:0]  out_tuser,  // updated
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [3:0]  cfg_wdata
);

  typedef struct packed {
    logic [1:0]          mode;
    logic [3:0]          mask;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic signed [15:0]  z;
    logic signed [15:0]  t;
    logic [1:0]          quad;
    logic signed [31:0]  cx;
    logic signed [31:0]  cy;
    logic signed [15:0]  cz;
    logic signed [33:0]  tl_p;
    logic signed [33:0]  tr_p;
    logic signed [15:0]  tl;
    logic signed [15:0]  tr;
    logic signed [15:0]  sn;
    logic signed [15:0]  cs;
    logic signed [31:0]  xc;
    logic signed [31:0]  ys;
    logic signed [31:0]  xs;
    logic signed [31:0]  yc;
    logic signed [17:0]  rx;
    logic signed [17:0]  ry;
    logic signed [18:0]  w0;
    logic signed [18:0]  w1;
    logic signed [18:0]  w2;
    logic signed [18:0]  w3;
    logic signed [33:0]  p0;
    logic signed [33:0]  p1;
    logic signed [33:0]  p2;
    logic signed [33:0]  p3;
    logic [3:0][32:0]    a;
    logic [32:0]         m01;
    logic [32:0]         m23;
    logic [32:0]         m;
    logic                big;
    logic [3:0]          neg;
    logic signed [15:0]  sm0;
    logic signed [15:0]  sm1;
    logic signed [15:0]  sm2;
    logic signed [15:0]  sm3;
    logic [3:0][NUM_W-1:0] num;
  } pipe_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         mask;
    logic signed [15:0] tl;
    logic signed [15:0] tr;
    logic               big;
    logic [3:0]         neg;
    logic signed [15:0] sm0;
    logic signed [15:0] sm1;
    logic signed [15:0] sm2;
    logic signed [15:0] sm3;
  } side_t;

  logic [1:0] drive_mode_r;
  logic [3:0] invert_mask_r;

  logic                    en;
  logic [FRONT_STAGES-1:0] vd_r;
  logic [QUO_W-1:0]        vs_r;
  pipe_t                   st_r [FRONT_STAGES];
  pipe_t                   st_nxt [FRONT_STAGES];
  side_t                   sb_r [QUO_W];
  logic [QUO_W-1:0]        quo [4];
  logic                    out_tvalid_r;
  logic [63:0]             out_tdata_r;
  logic [63:0]             out_tdata_nxt;
  logic                    out_tuser_r;
  logic                    out_tuser_nxt;
  logic signed [16:0]      dyx;
  logic signed [16:0]      syx;

  // The pipeline moves as one whenever the output register can take a word.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r  <= MODE_TANK;
      invert_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DRIVE_MODE:  drive_mode_r  <= cfg_wdata[1:0];
        REG_INVERT_MASK: invert_mask_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // One CORDIC rotation step toward the residual angle.
  function automatic pipe_t cordic_step(input pipe_t p, input logic [3:0] i);
    pipe_t r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    r = p;
    dx = p.cy >>> i;
    dy = p.cx >>> i;
    if (p.cz >= 0) begin
      r.cx = p.cx - dx;
      r.cy = p.cy + dy;
      r.cz = p.cz - atan_bam(i);
    end else begin
      r.cx = p.cx + dx;
      r.cy = p.cy - dy;
      r.cz = p.cz + atan_bam(i);
    end
    return r;
  endfunction

  assign dyx = 17'(st_r[0].y) - 17'(st_r[0].x);
  assign syx = 17'(st_r[0].y) + 17'(st_r[0].x);

  // Front pipeline: capture, CORDIC, rotation, mixing and peak search.
  always_comb begin
    logic signed [15:0] rc;
    logic signed [15:0] rs;
    logic [32:0]        mm;
    pipe_t              q;

    // Capture.
    st_nxt[0]      = '0;
    st_nxt[0].mode = drive_mode_r;
    st_nxt[0].mask = invert_mask_r;
    st_nxt[0].x    = in_tdata[15:0];
    st_nxt[0].y    = in_tdata[31:16];
    st_nxt[0].z    = in_tdata[47:32];
    st_nxt[0].t    = in_tdata[63:48];
    st_nxt[0].quad = in_tdata[79:78];
    st_nxt[0].cx   = CORDIC_GAIN;
    st_nxt[0].cy   = '0;
    st_nxt[0].cz   = {2'b00, in_tdata[77:64]};

    // CORDIC stages; the tank products ride along.
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      st_nxt[k] = cordic_step(st_r[k-1], 4'(k - 1));
    end
    st_nxt[1].tl_p = -(34'(dyx * st_r[0].t));
    st_nxt[1].tr_p = 34'(syx * st_r[0].t);
    st_nxt[2].tl   = sat14(rnd14(48'(st_r[1].tl_p)));
    st_nxt[2].tr   = sat14(rnd14(48'(st_r[1].tr_p)));

    // Quadrant mapping of sine and cosine.
    q = st_r[14];
    rc = q30_to_q14(q.cx);
    rs = q30_to_q14(q.cy);
    case (q.quad)
      2'd0: begin q.cs = rc;  q.sn = rs;  end
      2'd1: begin q.cs = -rs; q.sn = rc;  end
      2'd2: begin q.cs = -rc; q.sn = -rs; end
      default: begin q.cs = rs; q.sn = -rc; end
    endcase
    st_nxt[15] = q;

    // Rotation products.
    q = st_r[15];
    q.xc = q.x * q.cs;
    q.ys = q.y * q.sn;
    q.xs = q.x * q.sn;
    q.yc = q.y * q.cs;
    st_nxt[16] = q;

    // Rotated stick, back to Q14.
    q = st_r[16];
    q.rx = 18'(rnd14(48'(q.xc) - 48'(q.ys)));
    q.ry = 18'(rnd14(48'(q.xs) + 48'(q.yc)));
    st_nxt[17] = q;

    // Wheel sums.
    q = st_r[17];
    q.w0 = 19'(q.rx) + 19'(q.ry) + 19'(q.z);
    q.w1 = 19'(q.ry) + 19'(q.z) - 19'(q.rx);
    q.w2 = 19'(q.ry) - 19'(q.rx) - 19'(q.z);
    q.w3 = 19'(q.rx) + 19'(q.ry) - 19'(q.z);
    st_nxt[18] = q;

    // Throttle products in Q28.
    q = st_r[18];
    q.p0 = 34'(q.w0 * q.t);
    q.p1 = 34'(q.w1 * q.t);
    q.p2 = 34'(q.w2 * q.t);
    q.p3 = 34'(q.w3 * q.t);
    st_nxt[19] = q;

    // Magnitudes and first level of the peak search.
    q = st_r[19];
    q.a[0] = mag34(q.p0);
    q.a[1] = mag34(q.p1);
    q.a[2] = mag34(q.p2);
    q.a[3] = mag34(q.p3);
    q.m01  = (q.a[0] > q.a[1]) ? q.a[0] : q.a[1];
    q.m23  = (q.a[2] > q.a[3]) ? q.a[2] : q.a[3];
    st_nxt[20] = q;

    // Peak, plain rounding path and divider numerators.
    q = st_r[20];
    mm = (q.m01 > q.m23) ? q.m01 : q.m23;
    q.m   = mm;
    q.big = mm > Q28_ONE;
    q.neg = {q.p3 < 0, q.p2 < 0, q.p1 < 0, q.p0 < 0};
    q.sm0 = sat14(rnd14(48'(q.p0)));
    q.sm1 = sat14(rnd14(48'(q.p1)));
    q.sm2 = sat14(rnd14(48'(q.p2)));
    q.sm3 = sat14(rnd14(48'(q.p3)));
    for (int i = 0; i < 4; i++) begin
      q.num[i] = NUM_W'({q.a[i], 14'b0}) + NUM_W'(mm >> 1);
    end
    st_nxt[21] = q;
  end

  // Four normalizing dividers, one per wheel.
  for (genvar g = 0; g < 4; g++) begin : g_div
    amwm_div u_div (
      .clk (clk),
      .en  (en),
      .num (st_r[FRONT_STAGES-1].num[g]),
      .den (st_r[FRONT_STAGES-1].m),
      .quo (quo[g])
    );
  end

  // Final selection, mode mux and per-wheel inversion.
  always_comb begin
    logic signed [15:0] w [4];
    logic signed [15:0] o [4];
    side_t s;
    s = sb_r[QUO_W-1];
    w[0] = s.big ? (s.neg[0] ? -16'(quo[0]) : 16'(quo[0])) : s.sm0;
    w[1] = s.big ? (s.neg[1] ? -16'(quo[1]) : 16'(quo[1])) : s.sm1;
    w[2] = s.big ? (s.neg[2] ? -16'(quo[2]) : 16'(quo[2])) : s.sm2;
    w[3] = s.big ? (s.neg[3] ? -16'(quo[3]) : 16'(quo[3])) : s.sm3;
    out_tuser_nxt = 1'b1;
    case (s.mode)
      MODE_TANK: begin
        o[0] = s.tl;
        o[1] = s.tl;
        o[2] = s.tr;
        o[3] = s.tr;
      end
      MODE_MECANUM: begin
        o = w;
      end
      default: begin
        o[0] = '0;
        o[1] = '0;
        o[2] = '0;
        o[3] = '0;
        out_tuser_nxt = 1'b0;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      if (s.mask[i]) o[i] = -o[i];
    end
    out_tdata_nxt = {o[3], o[2], o[1], o[0]};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r         <= '0;
      vs_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vd_r         <= {vd_r[FRONT_STAGES-2:0], in_tvalid};
      vs_r         <= {vs_r[QUO_W-2:0], vd_r[FRONT_STAGES-1]};
      out_tvalid_r <= vs_r[QUO_W-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      sb_r[0].mode <= st_r[FRONT_STAGES-1].mode;
      sb_r[0].mask <= st_r[FRONT_STAGES-1].mask;
      sb_r[0].tl   <= st_r[FRONT_STAGES-1].tl;
      sb_r[0].tr   <= st_r[FRONT_STAGES-1].tr;
      sb_r[0].big  <= st_r[FRONT_STAGES-1].big;
      sb_r[0].neg  <= st_r[FRONT_STAGES-1].neg;
      sb_r[0].sm0  <= st_r[FRONT_STAGES-1].sm0;
      sb_r[0].sm1  <= st_r[FRONT_STAGES-1].sm1;
      sb_r[0].sm2  <= st_r[FRONT_STAGES-1].sm2;
      sb_r[0].sm3  <= st_r[FRONT_STAGES-1].sm3;
      for (int j = 1; j < QUO_W; j++) begin
        sb_r[j] <= sb_r[j-1];
      end
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Every delivered wheel command lies within plus or minus 1.0.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |->
      ($signed(out_tdata_r[15:0])  <= 16'sd16384 && $signed(out_tdata_r[15:0])  >= -16'sd16384 &&
       $signed(out_tdata_r[31:16]) <= 16'sd16384 && $signed(out_tdata_r[31:16]) >= -16'sd16384 &&
       $signed(out_tdata_r[47:32]) <= 16'sd16384 && $signed(out_tdata_r[47:32]) >= -16'sd16384 &&
       $signed(out_tdata_r[63:48]) <= 16'sd16384 && $signed(out_tdata_r[63:48]) >= -16'sd16384))
    else $error("wheel command out of range");

  // A word that drives no motors carries all-zero wheels.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r == '0))
    else $error("undriven word has nonzero wheels");

  // A stall freezes every valid bit in the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vd_r) && $stable(vs_r) && out_tvalid_r))
    else $error("pipeline moved during a stall");

  // A word leaving the divider lands in the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vs_r[QUO_W-1]) |=> out_tvalid_r)
    else $error("word lost at the output register");

endmodule

// ===== tb/tb_arcade_mecanum_wheel_mixer.sv =====
module tb_arcade_mecanum_wheel_mixer;
  import amwm_pkg::*;

  // One joystick sample as it travels on the input channel.
  typedef struct packed {
    logic [15:0] gyro_angle;
    logic [15:0] throttle;
    logic [15:0] stick_z;
    logic [15:0] stick_y;
    logic [15:0] stick_x;
  } stick_word_t;

  // Four wheel commands and the drive flag.
  typedef struct {
    logic signed [15:0] wheel [4];
    logic               updated;
  } wheel_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;    // stick_x, stick_y, stick_z, throttle, gyro_angle
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // front_left, rear_left, front_right, rear_right
  logic [0:0]  out_tuser;   // updated
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [3:0]  cfg_wdata;

  arcade_mecanum_wheel_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block's registers.
  logic [1:0] mix_mode;
  logic [3:0] mix_invert;

  wheel_cmd_t pending_cmds [$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         recv_hold;

  localparam longint ATAN_TBL [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                       41, 20, 10, 5, 3, 1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Division rounded half away from zero, d positive.
  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Sine and cosine of a binary angle in Q14, by quadrant plus CORDIC.
  function automatic void heading_sin_cos(input logic [15:0] angle, output longint s,
                                          output longint c);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint z;
    longint rc;
    longint rs;
    cx = 652032874;
    cy = 0;
    z = angle[13:0];
    for (int i = 0; i < 14; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= ATAN_TBL[i];
      end else begin
        cx += dx; cy -= dy; z += ATAN_TBL[i];
      end
    end
    rc = clamp_one((cx + 32768) >>> 16);
    rs = clamp_one((cy + 32768) >>> 16);
    case (angle[15:14])
      2'd0: begin c = rc;  s = rs;  end
      2'd1: begin c = -rs; s = rc;  end
      2'd2: begin c = -rc; s = -rs; end
      default: begin c = rs; s = -rc; end
    endcase
  endfunction

  // Wheel commands for one sample under the current registers.
  function automatic wheel_cmd_t mix_wheels(stick_word_t w);
    wheel_cmd_t r;
    longint x, y, z, t, s, c, rx, ry, m, a;
    longint wv [4];
    longint prod [4];
    x = longint'(signed'(w.stick_x));
    y = longint'(signed'(w.stick_y));
    z = longint'(signed'(w.stick_z));
    t = longint'(signed'(w.throttle));
    for (int i = 0; i < 4; i++) wv[i] = 0;
    r.updated = 1'b1;
    if (mix_mode == MODE_TANK) begin
      wv[0] = clamp_one(round_div(-(t * (y - x)), 16384));
      wv[1] = wv[0];
      wv[2] = clamp_one(round_div(t * (y + x), 16384));
      wv[3] = wv[2];
    end else if (mix_mode == MODE_MECANUM) begin
      heading_sin_cos(w.gyro_angle, s, c);
      rx = round_div(x * c - y * s, 16384);
      ry = round_div(x * s + y * c, 16384);
      prod[0] = (rx + ry + z) * t;
      prod[1] = (-rx + ry + z) * t;
      prod[2] = (-rx + ry - z) * t;
      prod[3] = (rx + ry - z) * t;
      m = 0;
      for (int i = 0; i < 4; i++) begin
        a = (prod[i] < 0) ? -prod[i] : prod[i];
        if (a > m) m = a;
      end
      for (int i = 0; i < 4; i++) begin
        if (m > 64'sd268435456) wv[i] = round_div(prod[i] * 16384, m);
        else wv[i] = round_div(prod[i], 16384);
        wv[i] = clamp_one(wv[i]);
      end
    end else begin
      r.updated = 1'b0;
    end
    for (int i = 0; i < 4; i++)
      r.wheel[i] = 16'(mix_invert[i] ? -wv[i] : wv[i]);
    return r;
  endfunction

  // Sender keeps valid high across back-to-back words and drops it only in gaps.
  task automatic send_stick(stick_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    pending_cmds.push_back(mix_wheels(w));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid = 1'b0;
  endtask

  // Registers change only once the pipeline has drained.
  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    stop_sending();
    wait (pending_cmds.size() == 0);
    repeat (45) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_DRIVE_MODE) mix_mode = val[1:0];
    else mix_invert = val;
  endtask

  function automatic logic [15:0] rand_q14();
    case ($urandom_range(9))
      0: return 16'(-16384);
      1: return 16'd16384;
      2: return 16'($urandom);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic stick_word_t rand_stick();
    stick_word_t w;
    w.stick_x = rand_q14();
    w.stick_y = rand_q14();
    w.stick_z = rand_q14();
    w.throttle = rand_q14();
    w.gyro_angle = ($urandom_range(4) == 0) ? 16'($urandom_range(3) << 14)
                                            : 16'($urandom);
    return w;
  endfunction

  function automatic stick_word_t make_stick(int x, int y, int z, int t, int g);
    stick_word_t w;
    w.stick_x = 16'(x); w.stick_y = 16'(y); w.stick_z = 16'(z);
    w.throttle = 16'(t); w.gyro_angle = 16'(g);
    return w;
  endfunction

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n || recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    wheel_cmd_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = pending_cmds.pop_front();
        if (out_tdata != {e.wheel[3], e.wheel[2], e.wheel[1], e.wheel[0]} ||
            out_tuser[0] != e.updated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected wheels %h upd %b, got %h upd %b",
                     {e.wheel[3], e.wheel[2], e.wheel[1], e.wheel[0]},
                     e.updated, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  task automatic test_tank();
    write_reg(REG_DRIVE_MODE, 4'(MODE_TANK));
    send_stick(make_stick(0, 0, 0, 0, 0));
    send_stick(make_stick(16384, 16384, 0, 16384, 0));
    send_stick(make_stick(-16384, 16384, 0, 16384, 0));
    send_stick(make_stick(16384, -16384, 0, -16384, 0));
    send_stick(make_stick(-32768, 32767, 0, 32767, 0));
    send_stick(make_stick(1, 0, 0, 8192, 0));
  endtask

  task automatic test_mecanum();
    write_reg(REG_DRIVE_MODE, 4'(MODE_MECANUM));
    send_stick(make_stick(0, 16384, 0, 16384, 0));
    send_stick(make_stick(16384, 0, 0, 16384, 16384));
    send_stick(make_stick(16384, 16384, 16384, 16384, 32768));
    send_stick(make_stick(-16384, -16384, -16384, -16384, 49152));
    send_stick(make_stick(8000, -3000, 2000, 16384, 8192));
    send_stick(make_stick(100, 100, 100, 4096, 65535));
    send_stick(make_stick(-32768, -32768, -32768, -32768, 24576));
  endtask

  task automatic test_swerve();
    write_reg(REG_DRIVE_MODE, 4'(MODE_SWERVE));
    send_stick(make_stick(16384, 16384, 16384, 16384, 0));
    // Mode 3 is unused and drives nothing; upper bits of the write are dropped.
    write_reg(REG_DRIVE_MODE, 4'hF);
    send_stick(make_stick(-16384, 5000, 0, 16384, 100));
  endtask

  task automatic test_invert();
    write_reg(REG_DRIVE_MODE, 4'(MODE_MECANUM));
    write_reg(REG_INVERT_MASK, 4'hF);
    send_stick(make_stick(16384, 16384, 16384, 16384, 0));
    write_reg(REG_INVERT_MASK, 4'h5);
    send_stick(make_stick(3000, 16384, -2000, 16384, 4000));
    write_reg(REG_DRIVE_MODE, 4'(MODE_TANK));
    write_reg(REG_INVERT_MASK, 4'hA);
    send_stick(make_stick(3000, 16384, 0, 16384, 0));
  endtask

  // Random samples over register settings and idling patterns.
  task automatic test_random();
    logic [3:0] modes [6] = '{4'd0, 4'd1, 4'd2, 4'd7, 4'd1, 4'd0};
    logic [3:0] masks [6] = '{4'd0, 4'd15, 4'd5, 4'd9, 4'd0, 4'd10};
    int send_pct [3] = '{18, 83, 0};
    int recv_pct [3] = '{83, 18, 0};
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 6; k++) begin
        write_reg(REG_DRIVE_MODE, modes[k]);
        write_reg(REG_INVERT_MASK, masks[k]);
        send_idle_pct = send_pct[p];
        recv_idle_pct = recv_pct[p];
        if (p == 2 && k == 1) begin
          fork
            begin
              recv_hold = 1'b1;
              repeat (300) @(negedge clk);
              recv_hold = 1'b0;
            end
          join_none
        end
        for (int n = 0; n < 72; n++) send_stick(rand_stick());
      end
    end
    stop_sending();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    mix_mode = MODE_TANK;
    mix_invert = 4'h0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_tank();
    test_mecanum();
    test_swerve();
    test_invert();
    test_random();

    wait (pending_cmds.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0)
      $display("[arcade_mecanum_wheel_mixer] OK");
    else
      $display("[arcade_mecanum_wheel_mixer] ERROR");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("[arcade_mecanum_wheel_mixer] ERROR");
    $finish;
  end

endmodule
